[src/ecb_pkg.sv]
// Endpoint circuit breaker package: payload words, configuration set,
// operation / cause / register codes and the saturating helpers.
// No dependencies.
package ecb_pkg;

	// Width of the call and failure counters of the ratio window
	localparam int COUNT_BITS = 20;
	localparam int PROD_W     = COUNT_BITS + 17;
	localparam int CMP_W      = 33;

	// Operation codes
	localparam logic [2:0] OP_CALL_OK   = 3'd0;
	localparam logic [2:0] OP_CALL_FAIL = 3'd1;
	localparam logic [2:0] OP_CONN_EXC  = 3'd2;
	localparam logic [2:0] OP_CONN_OK   = 3'd3;
	localparam logic [2:0] OP_CONN_TMO  = 3'd4;
	localparam logic [2:0] OP_AVAIL     = 3'd5;

	// Cause codes
	localparam logic [2:0] CAUSE_NONE      = 3'd0;
	localparam logic [2:0] CAUSE_FAIL_RUN  = 3'd1;
	localparam logic [2:0] CAUSE_RATIO     = 3'd2;
	localparam logic [2:0] CAUSE_CONN_EXC  = 3'd3;
	localparam logic [2:0] CAUSE_CONN_TMO  = 3'd4;
	localparam logic [2:0] CAUSE_RECOVERED = 3'd5;

	// Register indexes
	localparam logic [2:0] REG_CHECK_INTERVAL    = 3'd0;
	localparam logic [2:0] REG_MIN_FAIL_WINDOW   = 3'd1;
	localparam logic [2:0] REG_FAIL_LIMIT        = 3'd2;
	localparam logic [2:0] REG_MIN_TIMEOUT_COUNT = 3'd3;
	localparam logic [2:0] REG_TIMEOUT_RATIO     = 3'd4;
	localparam logic [2:0] REG_RETRY_INTERVAL    = 3'd5;
	localparam logic [2:0] REG_MAX_CONN_EXC      = 3'd6;

	// Register reset values
	localparam logic [15:0] RST_CHECK_INTERVAL    = 16'd60;
	localparam logic [15:0] RST_MIN_FAIL_WINDOW   = 16'd5;
	localparam logic [15:0] RST_FAIL_LIMIT        = 16'd5;
	localparam logic [15:0] RST_MIN_TIMEOUT_COUNT = 16'd2;
	localparam logic [16:0] RST_TIMEOUT_RATIO     = 17'd32768;
	localparam logic [15:0] RST_RETRY_INTERVAL    = 16'd30;
	localparam logic [15:0] RST_MAX_CONN_EXC      = 16'd1;

	typedef struct packed {
		logic [2:0]  operation;
		logic        timeout_flag;
		logic [31:0] now_seconds;
	} in_word_t;

	typedef struct packed {
		logic       is_active;
		logic       link_close;
		logic       use_allowed;
		logic [2:0] cause;
	} out_word_t;

	typedef struct packed {
		logic [15:0] check_interval;
		logic [15:0] min_fail_window;
		logic [15:0] fail_limit;
		logic [15:0] min_timeout_count;
		logic [16:0] timeout_ratio;
		logic [15:0] retry_interval;
		logic [15:0] max_conn_exc;
	} cfg_t;

	// Time stamp plus an interval, clamped at the top of the 32-bit range
	function automatic logic [31:0] time_add(input logic [31:0] now, input logic [15:0] delta);
		logic [32:0] sum;
		sum = {1'b0, now} + {17'b0, delta};
		return sum[32] ? {32{1'b1}} : sum[31:0];
	endfunction

	function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] v);
		return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic logic [15:0] inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

endpackage

[src/endpoint_circuit_breaker_top.sv]
// Endpoint circuit breaker, top level: input register, health core, result register.
// Depends on ecb_pkg, ecb_cfg and ecb_core.
//
// Tracks the health of one remote endpoint from a stream of time-stamped events
// (call ok / failed, connection exception / ok, connect-timeout flag, availability
// check) and returns exactly one result word per event word. The endpoint is
// disabled by a long enough run of failed calls, by the failure ratio over a check
// interval, by too many connection exceptions or by a raised connect-timeout flag;
// the last three also pulse link_close. One event word is taken every clock cycle
// while the output side keeps up; each word waits in the input register and then
// moves into the result register, where its result word is shown on out_word until
// the receiver takes it. The combinational path from input register to result
// register holds the 17 x COUNT_BITS ratio multiply and its compare. Configuration
// registers are written through cfg_wr_en / cfg_index / cfg_data; the user must
// write them only while no event is in flight, which the block does not enforce.
// Indexes beyond six are ignored.
module endpoint_circuit_breaker_top (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration write port
	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_index,
	input  logic [16:0]         cfg_data,
	// Event channel
	input  logic                in_valid,
	output logic                in_stall,
	input  ecb_pkg::in_word_t   in_word,
	// Result channel
	output logic                out_valid,
	input  logic                out_stall,
	output ecb_pkg::out_word_t  out_word
);

	ecb_pkg::cfg_t       cfg;
	ecb_pkg::in_word_t   in_word_s1;
	logic                in_valid_s1;
	ecb_pkg::out_word_t  out_word_s2;
	logic                out_valid_s2;
	ecb_pkg::out_word_t  core_result;
	logic                s2_free;
	logic                s1_adv;
	logic                in_acc;

	// Result register can load when empty or when its word leaves this cycle
	assign s2_free  = !out_valid_s2 || !out_stall;
	// The held event is processed (state update) as it moves into the result register
	assign s1_adv   = in_valid_s1 && s2_free;
	// Hold off the sender only while the input register is full and cannot drain
	assign in_stall = in_valid_s1 && !s2_free;
	assign in_acc   = in_valid && !in_stall;

	ecb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ecb_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (s1_adv),
		.word   (in_word_s1),
		.cfg    (cfg),
		.result (core_result)
	);

	// Input register: load on acceptance, drop the valid once it has advanced
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_acc) begin
			in_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			in_word_s1 <= in_word;
	end

	// Result register: advance whenever there is room, hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s2_free) begin
			out_valid_s2 <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv)
			out_word_s2 <= core_result;
	end

	assign out_valid = out_valid_s2;
	assign out_word  = out_word_s2;

endmodule

[src/ecb_cfg.sv]
// Configuration register file of the endpoint circuit breaker.
// Depends on ecb_pkg.
module ecb_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [2:0]          cfg_index,
	input  logic [16:0]         cfg_data,
	output ecb_pkg::cfg_t       cfg
);

	ecb_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.check_interval    <= ecb_pkg::RST_CHECK_INTERVAL;
			cfg_q.min_fail_window   <= ecb_pkg::RST_MIN_FAIL_WINDOW;
			cfg_q.fail_limit        <= ecb_pkg::RST_FAIL_LIMIT;
			cfg_q.min_timeout_count <= ecb_pkg::RST_MIN_TIMEOUT_COUNT;
			cfg_q.timeout_ratio     <= ecb_pkg::RST_TIMEOUT_RATIO;
			cfg_q.retry_interval    <= ecb_pkg::RST_RETRY_INTERVAL;
			cfg_q.max_conn_exc      <= ecb_pkg::RST_MAX_CONN_EXC;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ecb_pkg::REG_CHECK_INTERVAL:    cfg_q.check_interval    <= cfg_data[15:0];
				ecb_pkg::REG_MIN_FAIL_WINDOW:   cfg_q.min_fail_window   <= cfg_data[15:0];
				ecb_pkg::REG_FAIL_LIMIT:        cfg_q.fail_limit        <= cfg_data[15:0];
				ecb_pkg::REG_MIN_TIMEOUT_COUNT: cfg_q.min_timeout_count <= cfg_data[15:0];
				ecb_pkg::REG_TIMEOUT_RATIO:     cfg_q.timeout_ratio     <= cfg_data;
				ecb_pkg::REG_RETRY_INTERVAL:    cfg_q.retry_interval    <= cfg_data[15:0];
				ecb_pkg::REG_MAX_CONN_EXC:      cfg_q.max_conn_exc      <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[src/ecb_core.sv]
// Health state of the endpoint and the single-pass event update.
// Depends on ecb_pkg.
module ecb_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  ecb_pkg::in_word_t   word,
	input  ecb_pkg::cfg_t       cfg,
	output ecb_pkg::out_word_t  result
);

	localparam int CB = ecb_pkg::COUNT_BITS;

	logic          active_q, active_n;
	logic [CB-1:0] total_q, total_n;
	logic [CB-1:0] failed_q, failed_n;
	logic [15:0]   fail_run_q, fail_run_n;
	logic [31:0]   deadline_q, deadline_n;
	logic [31:0]   next_check_q, next_check_n;
	logic [31:0]   next_retry_q, next_retry_n;
	logic          exc_active_q, exc_active_n;
	logic [15:0]   exc_count_q, exc_count_n;
	logic          tmo_active_q, tmo_active_n;

	// Call path terms
	logic                      is_fail;
	logic [CB-1:0]             tot_inc, fail_inc;
	logic [15:0]               run_inc;
	logic [31:0]               dl_upd;
	logic                      run_trip;
	logic [ecb_pkg::PROD_W-1:0] ratio_lhs, ratio_rhs;
	logic                      ratio_trip;
	logic [31:0]               now;
	logic [31:0]               retry_at;

	assign now      = word.now_seconds;
	assign retry_at = ecb_pkg::time_add(now, cfg.retry_interval);

	assign is_fail  = (word.operation == ecb_pkg::OP_CALL_FAIL);
	assign tot_inc  = ecb_pkg::cnt_inc(total_q);
	assign fail_inc = is_fail ? ecb_pkg::cnt_inc(failed_q) : failed_q;
	assign run_inc  = ecb_pkg::inc16(fail_run_q);
	assign dl_upd   = (is_fail && fail_run_q == 16'd0) ?
			ecb_pkg::time_add(now, cfg.min_fail_window) : deadline_q;
	assign run_trip = is_fail && (run_inc >= cfg.fail_limit) && (now >= dl_upd);

	// Exact fixed-point ratio test: failed * 2^16 >= ratio * total
	assign ratio_lhs  = ecb_pkg::PROD_W'({fail_inc, 16'b0});
	assign ratio_rhs  = ecb_pkg::PROD_W'(cfg.timeout_ratio) * ecb_pkg::PROD_W'(tot_inc);
	assign ratio_trip = is_fail
			&& (ecb_pkg::CMP_W'(fail_inc) >= ecb_pkg::CMP_W'(cfg.min_timeout_count))
			&& (ratio_lhs >= ratio_rhs);

	always_comb begin
		active_n     = active_q;
		total_n      = total_q;
		failed_n     = failed_q;
		fail_run_n   = fail_run_q;
		deadline_n   = deadline_q;
		next_check_n = next_check_q;
		next_retry_n = next_retry_q;
		exc_active_n = exc_active_q;
		exc_count_n  = exc_count_q;
		tmo_active_n = tmo_active_q;
		result       = '0;

		case (word.operation)
			ecb_pkg::OP_CALL_OK, ecb_pkg::OP_CALL_FAIL: begin
				if (!active_q) begin
					if (!is_fail) begin
						active_n     = 1'b1;
						fail_run_n   = 16'd0;
						next_check_n = ecb_pkg::time_add(now, cfg.check_interval);
						total_n      = CB'(1);
						failed_n     = '0;
						tmo_active_n = 1'b0;
						exc_active_n = 1'b0;
						result.cause = ecb_pkg::CAUSE_RECOVERED;
					end
				end else begin
					total_n    = tot_inc;
					failed_n   = fail_inc;
					deadline_n = dl_upd;
					fail_run_n = is_fail ? run_inc : 16'd0;
					if (run_trip) begin
						active_n     = 1'b0;
						next_retry_n = retry_at;
						result.cause = ecb_pkg::CAUSE_FAIL_RUN;
					end else if (now > next_check_q) begin
						next_check_n = ecb_pkg::time_add(now, cfg.check_interval);
						if (ratio_trip) begin
							active_n          = 1'b0;
							next_retry_n      = retry_at;
							result.link_close = 1'b1;
							result.cause      = ecb_pkg::CAUSE_RATIO;
						end else begin
							total_n  = '0;
							failed_n = '0;
						end
					end
				end
			end
			ecb_pkg::OP_CONN_EXC: begin
				if (!exc_active_q) begin
					exc_count_n = ecb_pkg::inc16(exc_count_q);
					if (exc_count_q >= cfg.max_conn_exc) begin
						active_n          = 1'b0;
						next_retry_n      = retry_at;
						exc_active_n      = 1'b1;
						result.link_close = 1'b1;
						result.cause      = ecb_pkg::CAUSE_CONN_EXC;
					end
				end
			end
			ecb_pkg::OP_CONN_OK: begin
				exc_active_n = 1'b0;
				exc_count_n  = 16'd0;
				if (!active_q) begin
					active_n     = 1'b1;
					result.cause = ecb_pkg::CAUSE_RECOVERED;
				end
			end
			ecb_pkg::OP_CONN_TMO: begin
				if (word.timeout_flag != tmo_active_q) begin
					tmo_active_n = word.timeout_flag;
					if (word.timeout_flag) begin
						active_n          = 1'b0;
						next_retry_n      = retry_at;
						result.link_close = 1'b1;
						result.cause      = ecb_pkg::CAUSE_CONN_TMO;
					end
				end
			end
			ecb_pkg::OP_AVAIL: begin
				if (active_q || now >= next_retry_q) begin
					if (!active_q)
						next_retry_n = retry_at;
					result.use_allowed = 1'b1;
				end
			end
			default: begin
			end
		endcase

		result.is_active = active_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b1;
			total_q      <= '0;
			failed_q     <= '0;
			fail_run_q   <= 16'd0;
			deadline_q   <= 32'd0;
			next_check_q <= 32'd0;
			next_retry_q <= 32'd0;
			exc_active_q <= 1'b0;
			exc_count_q  <= 16'd0;
			tmo_active_q <= 1'b0;
		end else if (fire) begin
			active_q     <= active_n;
			total_q      <= total_n;
			failed_q     <= failed_n;
			fail_run_q   <= fail_run_n;
			deadline_q   <= deadline_n;
			next_check_q <= next_check_n;
			next_retry_q <= next_retry_n;
			exc_active_q <= exc_active_n;
			exc_count_q  <= exc_count_n;
			tmo_active_q <= tmo_active_n;
		end
	end

endmodule

[src/ecb_checker.sv]
// Port-level checker for the endpoint circuit breaker, bound to the top level.
// Depends on ecb_pkg and endpoint_circuit_breaker_top.
module ecb_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_stall,
	input  logic                out_valid,
	input  logic                out_stall,
	input  ecb_pkg::out_word_t  out_word
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// Input side never stalls while the output side drains
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output free");

	// Link close comes only with ratio, exception or timeout disables
	a_link_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.link_close |->
			(out_word.cause == ecb_pkg::CAUSE_RATIO ||
			 out_word.cause == ecb_pkg::CAUSE_CONN_EXC ||
			 out_word.cause == ecb_pkg::CAUSE_CONN_TMO) && !out_word.is_active)
		else $error("link close without a disabling cause");

	// A failure-run disable leaves the endpoint off with no link close
	a_run_cause: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.cause == ecb_pkg::CAUSE_FAIL_RUN |->
			!out_word.is_active && !out_word.link_close && !out_word.use_allowed)
		else $error("failure-run result inconsistent");

	// Recovery leaves the endpoint enabled
	a_recover: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.cause == ecb_pkg::CAUSE_RECOVERED |->
			out_word.is_active && !out_word.link_close)
		else $error("recovery result inconsistent");

endmodule

bind endpoint_circuit_breaker_top ecb_checker u_ecb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

[tb/tb_endpoint_circuit_breaker_top.sv]
// Self-checking testbench for endpoint_circuit_breaker_top: directed and random event words,
// a scoreboard class that predicts every result word, random idling on both channels.
// Depends on ecb_pkg and the endpoint_circuit_breaker_top RTL.
`timescale 1ns / 100ps

module tb_endpoint_circuit_breaker_top;
	import ecb_pkg::*;

	// Index past the last register: the block must ignore writes to it
	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int RND_PHASES     = 6;
	localparam int ITEMS_PER_PHASE = 75;
	localparam int HOLD_CYCLES    = 250;
	localparam int MAX_REPORTS    = 10;

	// Tracks the breaker state and queues the result word each event word should give
	class breaker_scoreboard;
		cfg_t                  regs;
		bit                    active;
		logic [COUNT_BITS-1:0] calls, fails;
		logic [15:0]           run_len, exc_count;
		logic [31:0]           run_deadline, check_due, retry_due;
		bit                    exc_latched, tmo_latched;
		out_word_t             result_q[$];
		int                    errors;
		int                    mismatches;

		function new();
			regs.check_interval    = RST_CHECK_INTERVAL;
			regs.min_fail_window   = RST_MIN_FAIL_WINDOW;
			regs.fail_limit        = RST_FAIL_LIMIT;
			regs.min_timeout_count = RST_MIN_TIMEOUT_COUNT;
			regs.timeout_ratio     = RST_TIMEOUT_RATIO;
			regs.retry_interval    = RST_RETRY_INTERVAL;
			regs.max_conn_exc      = RST_MAX_CONN_EXC;
			active       = 1'b1;
			calls        = '0;
			fails        = '0;
			run_len      = '0;
			exc_count    = '0;
			run_deadline = '0;
			check_due    = '0;
			retry_due    = '0;
			exc_latched  = 1'b0;
			tmo_latched  = 1'b0;
			errors       = 0;
			mismatches   = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [16:0] data);
			case (idx)
				REG_CHECK_INTERVAL:    regs.check_interval    = data[15:0];
				REG_MIN_FAIL_WINDOW:   regs.min_fail_window   = data[15:0];
				REG_FAIL_LIMIT:        regs.fail_limit        = data[15:0];
				REG_MIN_TIMEOUT_COUNT: regs.min_timeout_count = data[15:0];
				REG_TIMEOUT_RATIO:     regs.timeout_ratio     = data;
				REG_RETRY_INTERVAL:    regs.retry_interval    = data[15:0];
				REG_MAX_CONN_EXC:      regs.max_conn_exc      = data[15:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] add_secs(logic [31:0] t, logic [15:0] d);
			logic [32:0] s;
			s = {1'b0, t} + 33'(d);
			return s[32] ? 32'hFFFF_FFFF : s[31:0];
		endfunction

		function logic [COUNT_BITS-1:0] bump_count(logic [COUNT_BITS-1:0] v);
			return (&v) ? v : v + 1'b1;
		endfunction

		function logic [15:0] bump16(logic [15:0] v);
			return (&v) ? v : v + 16'd1;
		endfunction

		function void trip(logic [31:0] now);
			active    = 1'b0;
			retry_due = add_secs(now, regs.retry_interval);
		endfunction

		function void note_event(in_word_t w);
			out_word_t       r;
			logic [31:0]     now;
			logic [15:0]     old_exc;
			bit              failed, tripped;
			longint unsigned lhs, rhs;
			now = w.now_seconds;
			r.link_close  = 1'b0;
			r.use_allowed = 1'b0;
			r.cause       = CAUSE_NONE;
			case (w.operation)
				OP_CALL_OK, OP_CALL_FAIL: begin
					failed = (w.operation == OP_CALL_FAIL);
					if (!active) begin
						// a failed call on a disabled endpoint is dropped
						if (!failed) begin
							active      = 1'b1;
							run_len     = '0;
							check_due   = add_secs(now, regs.check_interval);
							calls       = COUNT_BITS'(1);
							fails       = '0;
							tmo_latched = 1'b0;
							exc_latched = 1'b0;
							r.cause     = CAUSE_RECOVERED;
						end
					end else begin
						tripped = 1'b0;
						calls = bump_count(calls);
						if (failed) begin
							fails = bump_count(fails);
							if (run_len == 16'd0)
								run_deadline = add_secs(now, regs.min_fail_window);
							run_len = bump16(run_len);
							if (run_len >= regs.fail_limit && now >= run_deadline) begin
								trip(now);
								r.cause = CAUSE_FAIL_RUN;
								tripped = 1'b1;
							end
						end else begin
							run_len = '0;
						end
						if (!tripped && now > check_due) begin
							check_due = add_secs(now, regs.check_interval);
							lhs = 64'(fails) << 16;
							rhs = 64'(regs.timeout_ratio) * 64'(calls);
							if (failed && 32'(fails) >= 32'(regs.min_timeout_count)
							    && lhs >= rhs) begin
								trip(now);
								r.link_close = 1'b1;
								r.cause      = CAUSE_RATIO;
							end else begin
								calls = '0;
								fails = '0;
							end
						end
					end
				end
				OP_CONN_EXC: begin
					if (!exc_latched) begin
						old_exc   = exc_count;
						exc_count = bump16(exc_count);
						if (old_exc >= regs.max_conn_exc) begin
							trip(now);
							exc_latched  = 1'b1;
							r.link_close = 1'b1;
							r.cause      = CAUSE_CONN_EXC;
						end
					end
				end
				OP_CONN_OK: begin
					exc_latched = 1'b0;
					exc_count   = '0;
					if (!active) begin
						active  = 1'b1;
						r.cause = CAUSE_RECOVERED;
					end
				end
				OP_CONN_TMO: begin
					if (w.timeout_flag != tmo_latched) begin
						tmo_latched = w.timeout_flag;
						if (w.timeout_flag) begin
							trip(now);
							r.link_close = 1'b1;
							r.cause      = CAUSE_CONN_TMO;
						end
					end
				end
				OP_AVAIL: begin
					if (!active && now < retry_due) begin
						r.use_allowed = 1'b0;
					end else begin
						if (!active)
							retry_due = add_secs(now, regs.retry_interval);
						r.use_allowed = 1'b1;
					end
				end
				default: ;
			endcase
			r.is_active = active;
			result_q = {result_q, r};
		endfunction

		function void check_result(out_word_t got);
			out_word_t want;
			if (result_q.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("[%0t] unexpected result word %h", $realtime, got);
				return;
			end
			want = result_q.pop_front();
			if (got.is_active !== want.is_active || got.link_close !== want.link_close ||
			    got.use_allowed !== want.use_allowed || got.cause !== want.cause) begin
				errors++;
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display({"[%0t] mismatch: expected active=%0b link=%0b use=%0b ",
						"cause=%0d, got active=%0b link=%0b use=%0b cause=%0d"},
						$realtime, want.is_active, want.link_close, want.use_allowed,
						want.cause, got.is_active, got.link_close, got.use_allowed,
						got.cause);
			end
		endfunction

		function int pending();
			return result_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [2:0]  cfg_index = REG_CHECK_INTERVAL;
	logic [16:0] cfg_data  = '0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_word_t    in_word   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_word_t   out_word;

	breaker_scoreboard sb;

	// Stimulus controls and state of the two channel processes
	bit          quiet;          // no idling on either side while set
	int          hold_asked;     // bumped by the sender to request a long hold-off
	int          hold_served;
	int          hold_left;
	logic [31:0] clock_s;        // running time stamp for well-formed traffic
	int          fail_burst;

	endpoint_circuit_breaker_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Result side: random stalls, or a long hold-off counted here once requested,
	// so that the pipeline fills and pushes back on the event channel
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_asked != hold_served) begin
			hold_served = hold_asked;
			hold_left   = HOLD_CYCLES;
			out_stall   <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(0, 99) < 19);
		end
	end

	// Check every result word taken by the receiver
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_word);
	end

	function automatic in_word_t ev(logic [2:0] op, logic flag, logic [31:0] t);
		in_word_t w;
		w.operation    = op;
		w.timeout_flag = flag;
		w.now_seconds  = t;
		return w;
	endfunction

	// Offer one event word, idling first at random; hold it until accepted
	task automatic send_event(in_word_t w);
		if (!quiet && $urandom_range(0, 99) < 19) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_event(w);
	endtask

	// Drop valid and wait until every outstanding result word has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Write every register, then the unused index, one write per cycle
	task automatic program_regs(cfg_t c);
		logic [16:0] vals [8];
		vals[REG_CHECK_INTERVAL]    = {1'($urandom_range(0, 1)), c.check_interval};
		vals[REG_MIN_FAIL_WINDOW]   = {1'($urandom_range(0, 1)), c.min_fail_window};
		vals[REG_FAIL_LIMIT]        = {1'($urandom_range(0, 1)), c.fail_limit};
		vals[REG_MIN_TIMEOUT_COUNT] = {1'($urandom_range(0, 1)), c.min_timeout_count};
		vals[REG_TIMEOUT_RATIO]     = c.timeout_ratio;
		vals[REG_RETRY_INTERVAL]    = {1'($urandom_range(0, 1)), c.retry_interval};
		vals[REG_MAX_CONN_EXC]      = {1'($urandom_range(0, 1)), c.max_conn_exc};
		vals[REG_UNUSED]            = 17'($urandom_range(0, 131071));
		for (int i = 0; i < 8; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= vals[i];
			@(posedge clk);
			sb.write_reg(3'(i), vals[i]);
		end
		cfg_wr_en <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	function automatic cfg_t pick_setting(int p);
		cfg_t c;
		c.check_interval    = 16'($urandom_range(0, 8));
		c.min_fail_window   = 16'($urandom_range(0, 4));
		c.fail_limit        = 16'($urandom_range(1, 4));
		c.min_timeout_count = 16'($urandom_range(0, 3));
		c.timeout_ratio     = 17'($urandom_range(0, 65536));
		c.retry_interval    = 16'($urandom_range(0, 10));
		c.max_conn_exc      = 16'($urandom_range(0, 3));
		case (p)
			1: begin
				// lowest values everywhere
				c.check_interval    = 16'd0;
				c.min_fail_window   = 16'd0;
				c.fail_limit        = 16'd1;
				c.min_timeout_count = 16'd0;
				c.timeout_ratio     = 17'd0;
				c.retry_interval    = 16'd0;
				c.max_conn_exc      = 16'd0;
			end
			3: begin
				// highest values everywhere
				c.check_interval    = 16'hFFFF;
				c.min_fail_window   = 16'hFFFF;
				c.fail_limit        = 16'hFFFF;
				c.min_timeout_count = 16'hFFFF;
				c.timeout_ratio     = 17'd65536;
				c.retry_interval    = 16'hFFFF;
				c.max_conn_exc      = 16'hFFFF;
			end
			4: c.timeout_ratio = 17'd65536;
			default: ;
		endcase
		return c;
	endfunction

	// Mostly small steps forward; now and then a jump anywhere, near the top or back
	function automatic logic [31:0] next_stamp();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			clock_s = $urandom;
		else if (r < 7)
			clock_s = 32'hFFFF_FFFF - 32'($urandom_range(0, 40));
		else if (r < 9)
			clock_s = clock_s - 32'($urandom_range(0, 5));
		else if (r < 15)
			clock_s = clock_s + 32'($urandom_range(0, 200));
		else if (r < 17)
			clock_s = clock_s + 32'($urandom_range(0, 70000));
		else
			clock_s = clock_s + 32'($urandom_range(0, 3));
		return clock_s;
	endfunction

	// Well-formed traffic with failure bursts, plus some noise words
	function automatic in_word_t make_event();
		int         r;
		logic [2:0] op;
		logic       flag;
		flag = 1'($urandom_range(0, 1));
		if (fail_burst > 0) begin
			fail_burst--;
			return ev(OP_CALL_FAIL, flag, next_stamp());
		end
		r = $urandom_range(0, 99);
		if (r < 10)
			return ev(3'($urandom_range(0, 7)), flag, $urandom);
		if (r < 30)
			op = OP_CALL_OK;
		else if (r < 50)
			op = OP_CALL_FAIL;
		else if (r < 55) begin
			op = OP_CALL_FAIL;
			fail_burst = $urandom_range(2, 8);
		end else if (r < 64)
			op = OP_CONN_EXC;
		else if (r < 71)
			op = OP_CONN_OK;
		else if (r < 80)
			op = OP_CONN_TMO;
		else if (r < 98)
			op = OP_AVAIL;
		else
			op = 3'($urandom_range(6, 7));
		return ev(op, flag, next_stamp());
	endfunction

	initial begin
		#2000000;
		$display("FAIL endpoint_circuit_breaker_top");
		$finish;
	end

	initial begin
		sb          = new();
		quiet       = 1'b0;
		hold_asked  = 0;
		hold_served = 0;
		hold_left   = 0;
		clock_s     = 32'd500;
		fail_burst  = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words on the reset settings
		send_event(ev(OP_CALL_OK,   1'b0, 32'd100));
		// failure run: limit reached only once the window has passed
		send_event(ev(OP_CALL_FAIL, 1'b1, 32'd101));
		send_event(ev(OP_CALL_FAIL, 1'b0, 32'd102));
		send_event(ev(OP_CALL_FAIL, 1'b0, 32'd103));
		send_event(ev(OP_CALL_FAIL, 1'b0, 32'd104));
		send_event(ev(OP_CALL_FAIL, 1'b0, 32'd105));
		send_event(ev(OP_CALL_FAIL, 1'b0, 32'd106));
		// failed call on a disabled endpoint, then availability before and at the retry time
		send_event(ev(OP_CALL_FAIL, 1'b0, 32'd107));
		send_event(ev(OP_AVAIL,     1'b0, 32'd110));
		send_event(ev(OP_AVAIL,     1'b1, 32'd136));
		send_event(ev(OP_CALL_OK,   1'b0, 32'd137));
		// connection exceptions, the latched one ignored, then recovery
		send_event(ev(OP_CONN_EXC,  1'b0, 32'd138));
		send_event(ev(OP_CONN_EXC,  1'b0, 32'd139));
		send_event(ev(OP_CONN_EXC,  1'b1, 32'd140));
		send_event(ev(OP_CONN_OK,   1'b0, 32'd141));
		// connect timeout raised, repeated, lowered; conn ok re-enables
		send_event(ev(OP_CONN_TMO,  1'b1, 32'd142));
		send_event(ev(OP_CONN_TMO,  1'b1, 32'd143));
		send_event(ev(OP_CONN_TMO,  1'b0, 32'd144));
		send_event(ev(OP_CONN_OK,   1'b1, 32'd145));
		// unused codes change nothing
		send_event(ev(3'd6,         1'b1, 32'hFFFF_FFFF));
		send_event(ev(3'd7,         1'b1, 32'd0));
		// ratio evaluation after the check interval
		send_event(ev(OP_CALL_FAIL, 1'b0, 32'd300));
		send_event(ev(OP_CALL_FAIL, 1'b0, 32'd400));
		// retry time clamped at the top of the range
		send_event(ev(OP_CONN_TMO,  1'b1, 32'hFFFF_FFF0));
		send_event(ev(OP_AVAIL,     1'b0, 32'hFFFF_FFFE));
		send_event(ev(OP_AVAIL,     1'b0, 32'hFFFF_FFFF));
		send_event(ev(OP_CALL_OK,   1'b0, 32'd0));

		// Random phases, each on its own register setting
		for (int p = 0; p < RND_PHASES; p++) begin
			drain();
			repeat (3) @(posedge clk);
			program_regs(pick_setting(p));
			quiet = (p == 2);
			if (p == 3)
				hold_asked++;
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// hold the sender back until the pipeline is empty
				if (p == 4 && i == ITEMS_PER_PHASE / 2)
					drain();
				send_event(make_event());
			end
		end
		quiet = 1'b0;

		drain();
		repeat (5) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS endpoint_circuit_breaker_top");
		else
			$display("FAIL endpoint_circuit_breaker_top");
		$finish;
	end

endmodule
